// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks, gated off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// post must hold in the cycle after pre
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- src/scti_pkg.sv -----
// ----------------------------------------------------------------------------
// scti_pkg
// Shared types and constants of the timer / interrupt unit.
// ----------------------------------------------------------------------------
`default_nettype none

package scti_pkg;

  localparam int DATA_W   = 8;
  localparam int ADDR_W   = 4;
  localparam int CMD_W    = 2;
  localparam int PERIOD_W = 23;
  localparam int COUNT_W  = 24;
  localparam int NUM_TMR  = 3;
  localparam int NUM_FREQ = 4;

  localparam int SLOW_BASE_DIV_DEF = 114;
  localparam int FAST_BASE_DIV_DEF = 28;
  localparam int QUEUE_DEPTH_DEF   = 2;

  localparam logic [DATA_W-1:0] TICK_CYCLES_RST = 8'd114;
  localparam logic [DATA_W-1:0] IRQ_STATUS_RST  = 8'hFF;
  localparam logic [DATA_W-1:0] RDATA_IDLE      = 8'hFF;
  localparam logic [DATA_W-1:0] IRQEN_SET_MASK  = 8'hF7;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX    = 23'h7FFFFF;

  // audio control bits
  localparam int AC_SLOW_BASE = 0;
  localparam int AC_JOIN34    = 3;
  localparam int AC_JOIN12    = 4;
  localparam int AC_FAST34    = 5;
  localparam int AC_FAST1     = 6;

  // commands
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

  // register addresses
  localparam logic [ADDR_W-1:0] ADDR_FREQ0  = 4'd0;
  localparam logic [ADDR_W-1:0] ADDR_FREQ1  = 4'd2;
  localparam logic [ADDR_W-1:0] ADDR_FREQ2  = 4'd4;
  localparam logic [ADDR_W-1:0] ADDR_FREQ3  = 4'd6;
  localparam logic [ADDR_W-1:0] ADDR_AUDCTL = 4'd8;
  localparam logic [ADDR_W-1:0] ADDR_START  = 4'd9;
  localparam logic [ADDR_W-1:0] ADDR_IRQ    = 4'd14;

  // decoded operations
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_NONE    = 3'd0;
  localparam logic [OP_W-1:0] OP_RD_STAT = 3'd1;
  localparam logic [OP_W-1:0] OP_WR_FREQ = 3'd2;
  localparam logic [OP_W-1:0] OP_WR_ACTL = 3'd3;
  localparam logic [OP_W-1:0] OP_WR_STRT = 3'd4;
  localparam logic [OP_W-1:0] OP_WR_IRQE = 3'd5;
  localparam logic [OP_W-1:0] OP_TICK    = 3'd6;

  // frequency register indexes
  localparam logic [1:0] FREQ_IDX0 = 2'd0;
  localparam logic [1:0] FREQ_IDX1 = 2'd1;
  localparam logic [1:0] FREQ_IDX2 = 2'd2;
  localparam logic [1:0] FREQ_IDX3 = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   code;
    logic [1:0]        fidx;
    logic [DATA_W-1:0] wdata;
  } op_t;

endpackage

`default_nettype wire

// ----- src/scti_front.sv -----
// ----------------------------------------------------------------------------
// scti_front
// Accepts input beats and decodes them into operations for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module scti_front (
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [scti_pkg::CMD_W-1:0]    in_tuser,  // [1:0] cmd
  input  wire logic [15:0]                   in_tdata,  // [3:0] addr, [11:4] wdata
  input  wire logic                          q_full,
  output logic                               q_push,
  output scti_pkg::op_t                      q_op
);
  import scti_pkg::*;

  logic [ADDR_W-1:0] addr;
  logic [DATA_W-1:0] wdata;

  assign addr      = in_tdata[ADDR_W-1:0];
  assign wdata     = in_tdata[ADDR_W+DATA_W-1:ADDR_W];
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_op.code  = OP_NONE;
    q_op.fidx  = FREQ_IDX0;
    q_op.wdata = wdata;
    case (in_tuser)
      CMD_READ: begin
        if (addr == ADDR_IRQ) q_op.code = OP_RD_STAT;
      end
      CMD_WRITE: begin
        case (addr)
          ADDR_FREQ0: begin
            q_op.code = OP_WR_FREQ;
            q_op.fidx = FREQ_IDX0;
          end
          ADDR_FREQ1: begin
            q_op.code = OP_WR_FREQ;
            q_op.fidx = FREQ_IDX1;
          end
          ADDR_FREQ2: begin
            q_op.code = OP_WR_FREQ;
            q_op.fidx = FREQ_IDX2;
          end
          ADDR_FREQ3: begin
            q_op.code = OP_WR_FREQ;
            q_op.fidx = FREQ_IDX3;
          end
          ADDR_AUDCTL: q_op.code = OP_WR_ACTL;
          ADDR_START:  q_op.code = OP_WR_STRT;
          ADDR_IRQ:    q_op.code = OP_WR_IRQE;
          default:     q_op.code = OP_NONE;
        endcase
      end
      CMD_TICK: q_op.code = OP_TICK;
      default:  q_op.code = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/scti_queue.sv -----
// ----------------------------------------------------------------------------
// scti_queue
// Small operation FIFO between the decoder and the execution stage.
// ----------------------------------------------------------------------------
`default_nettype none

module scti_queue #(
  parameter int DEPTH = scti_pkg::QUEUE_DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  scti_pkg::op_t      push_op,
  output logic               full,
  input  wire logic          pop,
  output scti_pkg::op_t      pop_op,
  output logic               empty,
  output logic [CNT_W-1:0]   count
);
  import scti_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  op_t              mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full   = (count_r == CNT_W'(DEPTH));
  assign empty  = (count_r == '0);
  assign count  = count_r;
  assign pop_op = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_op;
  end

endmodule

`default_nettype wire

// ----- src/scti_back.sv -----
// ----------------------------------------------------------------------------
// scti_back
// Executes one operation per cycle unless out_tready stalls: register writes,
// period recompute, timer ticks and status update; holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module scti_back #(
  parameter int SLOW_BASE_DIVISOR = scti_pkg::SLOW_BASE_DIV_DEF,
  parameter int FAST_BASE_DIVISOR = scti_pkg::FAST_BASE_DIV_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [scti_pkg::DATA_W-1:0]  cfg_wr_data,
  input  wire logic                         q_empty,
  input  scti_pkg::op_t                     q_op,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [15:0]                       out_tdata   // [7:0] rdata, [8] irq
);
  import scti_pkg::*;

  localparam logic [DATA_W-1:0] SLOW_BASE = DATA_W'(SLOW_BASE_DIVISOR);
  localparam logic [DATA_W-1:0] FAST_BASE = DATA_W'(FAST_BASE_DIVISOR);
  localparam logic signed [COUNT_W:0] COUNT_MIN = -(COUNT_W+1)'(24'h800000);

  function automatic logic [PERIOD_W-1:0] calc_period(
    input logic [DATA_W-1:0] hi,
    input logic [DATA_W-1:0] lo,
    input logic              joined,
    input logic              fast,
    input logic [DATA_W-1:0] base,
    input logic [DATA_W-1:0] tmin
  );
    logic [24:0]         v;
    logic [24:0]         p;
    logic [PERIOD_W-1:0] q;
    v = joined ? {9'd0, hi, lo} : {17'd0, lo};
    if (fast) p = v + (joined ? 25'd7 : 25'd4);
    else      p = (v + 25'd1) * {17'd0, base};
    q = (p > {2'b0, PERIOD_MAX}) ? PERIOD_MAX : p[PERIOD_W-1:0];
    if (q < {15'd0, tmin}) q = {15'd0, tmin};
    return q;
  endfunction

  logic [DATA_W-1:0]   tick_r;
  logic [DATA_W-1:0]   freq_r [NUM_FREQ];
  logic [DATA_W-1:0]   freq_nxt [NUM_FREQ];
  logic [DATA_W-1:0]   actl_r, actl_nxt;
  logic [DATA_W-1:0]   irqen_r, irqen_nxt;
  logic [DATA_W-1:0]   stat_r, stat_nxt;
  logic [PERIOD_W-1:0] period_r [NUM_TMR];
  logic [PERIOD_W-1:0] period_nxt [NUM_TMR];
  logic [COUNT_W-1:0]  count_r [NUM_TMR];
  logic [COUNT_W-1:0]  count_nxt [NUM_TMR];
  logic [NUM_TMR-1:0]  sel;
  logic [DATA_W-1:0]   base;
  logic [PERIOD_W-1:0] calc [NUM_TMR];
  logic signed [COUNT_W:0] cnt [NUM_TMR];
  logic [DATA_W-1:0]   rdata;
  logic                irq_nxt;
  logic                out_valid_r;
  logic [15:0]         out_data_r;

  assign q_pop      = !q_empty && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    for (int i = 0; i < NUM_FREQ; i++) freq_nxt[i] = freq_r[i];
    actl_nxt  = actl_r;
    irqen_nxt = irqen_r;
    stat_nxt  = stat_r;
    sel       = '0;
    for (int i = 0; i < NUM_TMR; i++) begin
      count_nxt[i] = count_r[i];
      cnt[i]       = '0;
    end

    case (q_op.code)
      OP_WR_FREQ: begin
        freq_nxt[q_op.fidx] = q_op.wdata;
        case (q_op.fidx)
          FREQ_IDX0: sel = actl_r[AC_JOIN12] ? 3'b011 : 3'b001;
          FREQ_IDX1: sel = 3'b010;
          FREQ_IDX2: sel = actl_r[AC_JOIN34] ? 3'b100 : 3'b000;
          FREQ_IDX3: sel = 3'b100;
          default:   sel = 3'b000;
        endcase
      end
      OP_WR_ACTL: begin
        actl_nxt = q_op.wdata;
        sel      = 3'b111;
      end
      OP_WR_STRT: begin
        for (int i = 0; i < NUM_TMR; i++) count_nxt[i] = {1'b0, period_r[i]};
      end
      OP_WR_IRQE: begin
        irqen_nxt = q_op.wdata;
        stat_nxt  = stat_r | (~q_op.wdata & IRQEN_SET_MASK);
      end
      OP_TICK: begin
        for (int i = 0; i < NUM_TMR; i++) begin
          cnt[i] = $signed({count_r[i][COUNT_W-1], count_r[i]})
                 - $signed({17'd0, tick_r});
          if (cnt[i] < COUNT_MIN) cnt[i] = COUNT_MIN;
          if (cnt[i][COUNT_W]) begin
            cnt[i] = cnt[i] + $signed({2'b0, period_r[i]});
            if (irqen_r[i]) stat_nxt[i] = 1'b0;
          end
          count_nxt[i] = cnt[i][COUNT_W-1:0];
        end
      end
      default: ;
    endcase

    base    = actl_nxt[AC_SLOW_BASE] ? SLOW_BASE : FAST_BASE;
    calc[0] = calc_period(freq_nxt[0], freq_nxt[0], 1'b0, actl_nxt[AC_FAST1],
                          base, tick_r);
    calc[1] = calc_period(freq_nxt[1], actl_nxt[AC_JOIN12] ? freq_nxt[0] : freq_nxt[1],
                          actl_nxt[AC_JOIN12],
                          actl_nxt[AC_JOIN12] && actl_nxt[AC_FAST1], base, tick_r);
    calc[2] = calc_period(freq_nxt[3], actl_nxt[AC_JOIN34] ? freq_nxt[2] : freq_nxt[3],
                          actl_nxt[AC_JOIN34],
                          actl_nxt[AC_JOIN34] && actl_nxt[AC_FAST34], base, tick_r);
    for (int i = 0; i < NUM_TMR; i++) period_nxt[i] = sel[i] ? calc[i] : period_r[i];

    rdata   = (q_op.code == OP_RD_STAT) ? stat_r : RDATA_IDLE;
    irq_nxt = |(~stat_nxt & irqen_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= TICK_CYCLES_RST;
      actl_r      <= '0;
      irqen_r     <= '0;
      stat_r      <= IRQ_STATUS_RST;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_FREQ; i++) freq_r[i] <= '0;
      for (int i = 0; i < NUM_TMR; i++) begin
        period_r[i] <= '0;
        count_r[i]  <= '0;
      end
    end else begin
      if (cfg_wr_en) tick_r <= cfg_wr_data;
      if (q_pop) begin
        actl_r  <= actl_nxt;
        irqen_r <= irqen_nxt;
        stat_r  <= stat_nxt;
        for (int i = 0; i < NUM_FREQ; i++) freq_r[i] <= freq_nxt[i];
        for (int i = 0; i < NUM_TMR; i++) begin
          period_r[i] <= period_nxt[i];
          count_r[i]  <= count_nxt[i];
        end
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) out_data_r <= {7'd0, irq_nxt, rdata};
  end

endmodule

`default_nettype wire

// ----- src/sound_chip_timer_irq_unit_top.sv -----
// ----------------------------------------------------------------------------
// sound_chip_timer_irq_unit_top
// Timer and interrupt section of a four-channel sound chip.
// ----------------------------------------------------------------------------
// One beat in gives one beat out (read data and irq level after the command).
// While out_tready is high a new beat is taken every cycle; a beat is decoded
// into the queue when it is taken and is then executed from the queue into
// the result register. With out_tready low the queue holds QUEUE_DEPTH beats
// before in_tready drops. The execute stage, with its period multiplier and
// counter update, sets the rate of one beat per cycle while out_tready is
// high. The user must see that tick_cycles is written through cfg_wr_en /
// cfg_wr_data only while no beat is in flight; the block does not enforce it.
`default_nettype none

module sound_chip_timer_irq_unit_top #(
  parameter int SLOW_BASE_DIVISOR = scti_pkg::SLOW_BASE_DIV_DEF,
  parameter int FAST_BASE_DIVISOR = scti_pkg::FAST_BASE_DIV_DEF,
  parameter int QUEUE_DEPTH       = scti_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_wr_en,
  input  wire logic [7:0]   cfg_wr_data,  // tick_cycles
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [1:0]   in_tuser,     // [1:0] cmd
  input  wire logic [15:0]  in_tdata,     // [3:0] addr, [11:4] wdata
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [15:0]       out_tdata     // [7:0] rdata, [8] irq
);
  import scti_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t              push_op;
  op_t              pop_op;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  logic [CNT_W-1:0] q_count;

  scti_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_op      (push_op)
  );

  scti_queue #(
    .DEPTH (QUEUE_DEPTH),
    .CNT_W (CNT_W)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (q_pop),
    .pop_op  (pop_op),
    .empty   (q_empty),
    .count   (q_count)
  );

  scti_back #(
    .SLOW_BASE_DIVISOR (SLOW_BASE_DIVISOR),
    .FAST_BASE_DIVISOR (FAST_BASE_DIVISOR)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_empty     (q_empty),
    .q_op        (pop_op),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_q_bound, q_count <= CNT_W'(QUEUE_DEPTH), "queue over depth")
  `ASSERT_ALWAYS(a_rdy_full, in_tready || (q_count == CNT_W'(QUEUE_DEPTH)), "early stall")
  `ASSERT_NEXT(a_drain, !q_empty && (!out_tvalid || out_tready), out_tvalid, "op not run")

endmodule

`default_nettype wire

// ----- sim/timer_irq_checker.sv -----
// ----------------------------------------------------------------------------
// timer_irq_checker
// Watches the command and result streams of the timer / interrupt unit. It
// keeps its own copy of the frequency, control, enable, status, period and
// counter state, computes the read data and irq level for each accepted
// command beat, and compares the result beats in order against them.
// ----------------------------------------------------------------------------
module timer_irq_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [1:0]  in_tuser,    // [1:0] cmd
  input  wire logic [15:0] in_tdata,    // [3:0] addr, [11:4] wdata
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [15:0] out_tdata,   // [7:0] rdata, [8] irq
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import scti_pkg::*;

  localparam logic [2:0] SEL_T1 = 3'b001;
  localparam logic [2:0] SEL_T2 = 3'b010;
  localparam logic [2:0] SEL_T4 = 3'b100;
  localparam int COUNT_FLOOR = -(1 << 23);

  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic              irq;
  } bus_result_t;

  bus_result_t due_q[$];

  logic [DATA_W-1:0]          tick_cycles;
  logic [DATA_W-1:0]          freq [NUM_FREQ];
  logic [DATA_W-1:0]          aud_ctl;
  logic [DATA_W-1:0]          irq_en;
  logic [DATA_W-1:0]          irq_stat;
  logic [PERIOD_W-1:0]        period [NUM_TMR];
  logic signed [COUNT_W-1:0]  count [NUM_TMR];
  int                         errs = 0;

  function automatic logic [PERIOD_W-1:0] fit_period(input int unsigned p);
    if (p > PERIOD_MAX) p = 32'(PERIOD_MAX);
    if (p < tick_cycles) p = 32'(tick_cycles);
    return p[PERIOD_W-1:0];
  endfunction

  function automatic void refresh_periods(input logic [2:0] sel);
    int unsigned base, f0, f1, f2, f3, p;
    base = aud_ctl[AC_SLOW_BASE] ? SLOW_BASE_DIV_DEF : FAST_BASE_DIV_DEF;
    f0 = freq[FREQ_IDX0];
    f1 = freq[FREQ_IDX1];
    f2 = freq[FREQ_IDX2];
    f3 = freq[FREQ_IDX3];
    if (sel[0]) begin
      p = aud_ctl[AC_FAST1] ? f0 + 4 : (f0 + 1) * base;
      period[0] = fit_period(p);
    end
    if (sel[1]) begin
      if (aud_ctl[AC_JOIN12])
        p = aud_ctl[AC_FAST1] ? f1 * 256 + f0 + 7 : (f1 * 256 + f0 + 1) * base;
      else
        p = (f1 + 1) * base;
      period[1] = fit_period(p);
    end
    if (sel[2]) begin
      if (aud_ctl[AC_JOIN34])
        p = aud_ctl[AC_FAST34] ? f3 * 256 + f2 + 7 : (f3 * 256 + f2 + 1) * base;
      else
        p = (f3 + 1) * base;
      period[2] = fit_period(p);
    end
  endfunction

  function automatic void bus_write(input logic [ADDR_W-1:0] a,
                                    input logic [DATA_W-1:0] v);
    case (a)
      ADDR_FREQ0: begin
        freq[FREQ_IDX0] = v;
        refresh_periods(aud_ctl[AC_JOIN12] ? (SEL_T1 | SEL_T2) : SEL_T1);
      end
      ADDR_FREQ1: begin
        freq[FREQ_IDX1] = v;
        refresh_periods(SEL_T2);
      end
      ADDR_FREQ2: begin
        freq[FREQ_IDX2] = v;
        if (aud_ctl[AC_JOIN34]) refresh_periods(SEL_T4);
      end
      ADDR_FREQ3: begin
        freq[FREQ_IDX3] = v;
        refresh_periods(SEL_T4);
      end
      ADDR_AUDCTL: begin
        aud_ctl = v;
        refresh_periods(SEL_T1 | SEL_T2 | SEL_T4);
      end
      ADDR_START: begin
        for (int i = 0; i < NUM_TMR; i++) count[i] = $signed({1'b0, period[i]});
      end
      ADDR_IRQ: begin
        irq_en = v;
        irq_stat = irq_stat | (~v & IRQEN_SET_MASK);
      end
      default: ;
    endcase
  endfunction

  function automatic void line_tick();
    int c;
    for (int i = 0; i < NUM_TMR; i++) begin
      c = int'(count[i]) - int'(tick_cycles);
      if (c < COUNT_FLOOR) c = COUNT_FLOOR;
      if (c < 0) begin
        c = c + int'(period[i]);
        if (irq_en[i]) irq_stat[i] = 1'b0;
      end
      count[i] = c[COUNT_W-1:0];
    end
  endfunction

  function automatic bus_result_t predict(input logic [CMD_W-1:0] cmd,
                                          input logic [ADDR_W-1:0] a,
                                          input logic [DATA_W-1:0] v);
    bus_result_t r;
    r.rdata = RDATA_IDLE;
    case (cmd)
      CMD_READ:  if (a == ADDR_IRQ) r.rdata = irq_stat;
      CMD_WRITE: bus_write(a, v);
      CMD_TICK:  line_tick();
      default: ;
    endcase
    r.irq = |(~irq_stat & irq_en);
    return r;
  endfunction

  always @(posedge clk) begin
    bus_result_t want;
    bus_result_t got;
    if (!rst_n) begin
      tick_cycles = TICK_CYCLES_RST;
      aud_ctl = '0;
      irq_en = '0;
      irq_stat = IRQ_STATUS_RST;
      for (int i = 0; i < NUM_FREQ; i++) freq[i] = '0;
      for (int i = 0; i < NUM_TMR; i++) begin
        period[i] = '0;
        count[i] = '0;
      end
      due_q.delete();
    end else begin
      if (cfg_wr_en) tick_cycles = cfg_wr_data;
      if (in_tvalid && in_tready)
        due_q.push_back(predict(in_tuser, in_tdata[3:0], in_tdata[11:4]));
      if (out_tvalid && out_tready) begin
        got.rdata = out_tdata[7:0];
        got.irq = out_tdata[8];
        if (due_q.size() == 0) begin
          errs++;
          $error("result beat with nothing expected: %04h", out_tdata);
        end else begin
          want = due_q.pop_front();
          if (got.rdata !== want.rdata) begin
            errs++;
            $error("rdata: expected %02h, got %02h", want.rdata, got.rdata);
          end
          if (got.irq !== want.irq) begin
            errs++;
            $error("irq: expected %0b, got %0b", want.irq, got.irq);
          end
        end
      end
    end
    pending <= due_q.size();
    fail_count <= errs;
  end

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus for the timer / interrupt unit: a run of ticks while the periods
// are still zero so the counters run away, a short directed set of bus
// accesses, then random timer programming sequences and noise under several
// tick_cycles settings, with random gaps on both streams. Checking is done by
// timer_irq_checker.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import scti_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [1:0]  in_tuser;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  int          fail_count;
  int          pending;
  int          idle_odds = 0;
  int          beats_sent = 0;

  sound_chip_timer_irq_unit_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  timer_irq_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 99) < idle_odds) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // valid stays high between back-to-back beats
  task automatic send_beat(input logic [1:0] cmd, input logic [3:0] a, input logic [7:0] v);
    if ($urandom_range(0, 99) < idle_odds) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tuser <= cmd;
    in_tdata <= {4'b0, v, a};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_tick(input logic [7:0] v);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // periods are still zero from reset, so counters keep running down
  task automatic runaway_soak();
    set_tick(8'd255);
    idle_odds = 10;
    send_beat(CMD_WRITE, ADDR_IRQ, 8'h07);
    repeat (2) begin
      repeat (100) send_beat(CMD_TICK, $urandom_range(0, 15), $urandom_range(0, 255));
      send_beat(CMD_READ, ADDR_IRQ, 8'h00);
      send_beat(CMD_WRITE, ADDR_IRQ, 8'h00);
      send_beat(CMD_WRITE, ADDR_IRQ, 8'h07);
    end
  endtask

  task automatic timer_burst();
    int k;
    logic [3:0] a;
    send_beat(CMD_WRITE, ADDR_AUDCTL, $urandom_range(0, 255));
    repeat ($urandom_range(1, 5)) begin
      k = $urandom_range(0, 3);
      case (k)
        0: a = ADDR_FREQ0;
        1: a = ADDR_FREQ1;
        2: a = ADDR_FREQ2;
        default: a = ADDR_FREQ3;
      endcase
      send_beat(CMD_WRITE, a,
                ($urandom_range(0, 9) < 7) ? $urandom_range(0, 6) : $urandom_range(0, 255));
    end
    send_beat(CMD_WRITE, ADDR_IRQ, $urandom_range(0, 255));
    if ($urandom_range(0, 4) != 0) send_beat(CMD_WRITE, ADDR_START, $urandom_range(0, 255));
    repeat ($urandom_range(1, 16)) begin
      send_beat(CMD_TICK, $urandom_range(0, 15), $urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) send_beat(CMD_READ, ADDR_IRQ, $urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0) send_beat(CMD_WRITE, ADDR_IRQ, $urandom_range(0, 255));
    end
    send_beat(CMD_READ, ADDR_IRQ, 8'h00);
  endtask

  task automatic random_phase(input logic [7:0] tick, input int beats, input int odds);
    int first;
    set_tick(tick);
    idle_odds = odds;
    first = beats_sent;
    while (beats_sent - first < beats) begin
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 4))
          send_beat($urandom_range(0, 3), $urandom_range(0, 15), $urandom_range(0, 255));
      else
        timer_burst();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    runaway_soak();

    set_tick(TICK_CYCLES_RST);
    idle_odds = 20;
    send_beat(CMD_READ, ADDR_IRQ, 8'h00);
    send_beat(CMD_READ, 4'd3, 8'hFF);
    send_beat(CMD_NOP, 4'd15, 8'hFF);
    send_beat(CMD_WRITE, ADDR_IRQ, 8'hFF);
    send_beat(CMD_READ, ADDR_IRQ, 8'h00);
    send_beat(CMD_WRITE, ADDR_IRQ, 8'h00);
    send_beat(CMD_WRITE, ADDR_AUDCTL, 8'h79);
    send_beat(CMD_WRITE, ADDR_FREQ0, 8'hFF);
    send_beat(CMD_WRITE, ADDR_FREQ1, 8'hFF);
    send_beat(CMD_WRITE, ADDR_FREQ2, 8'hFF);
    send_beat(CMD_WRITE, ADDR_FREQ3, 8'hFF);
    send_beat(CMD_WRITE, ADDR_AUDCTL, 8'h18);
    send_beat(CMD_WRITE, ADDR_FREQ2, 8'h00);
    send_beat(CMD_WRITE, ADDR_FREQ0, 8'h00);
    send_beat(CMD_WRITE, ADDR_FREQ3, 8'h00);
    send_beat(CMD_WRITE, ADDR_AUDCTL, 8'h01);
    send_beat(CMD_WRITE, ADDR_IRQ, 8'h07);
    send_beat(CMD_WRITE, ADDR_START, 8'h00);
    send_beat(CMD_TICK, 4'd0, 8'h00);
    send_beat(CMD_TICK, 4'd15, 8'hFF);
    send_beat(CMD_READ, ADDR_IRQ, 8'h00);
    send_beat(CMD_WRITE, 4'd15, 8'hA5);
    send_beat(CMD_WRITE, 4'd1, 8'h5A);
    send_beat(CMD_WRITE, ADDR_IRQ, 8'h08);
    send_beat(CMD_READ, ADDR_IRQ, 8'h00);

    random_phase(8'd1, 160, 30);
    random_phase(8'd255, 160, 30);
    random_phase(TICK_CYCLES_RST, 160, 0);
    random_phase($urandom_range(2, 254), 160, 40);
    random_phase(8'd28, 160, 20);
    random_phase($urandom_range(2, 254), 160, 30);
    random_phase(8'd1, 160, 15);
    random_phase($urandom_range(100, 255), 160, 0);

    wait_idle();
    repeat (4) @(posedge clk);
    if (fail_count == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
